/* rtl/mp2_pkg.sv */
// Shared constants, types and register clamps for the 2x2 max pooling unit.
package mp2_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int MAX_CHANNELS = 256;
  localparam int DIM_BITS     = 11;
  localparam int CHAN_CFG_BITS = 9;
  localparam int CFG_BITS     = 11;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int CHAN_BITS    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HALF_SLOTS   = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_BITS    = $clog2(HALF_SLOTS);
  localparam int INDEX_BITS   = 28;

  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_reg_t;

  // best of one column pair of the upper row
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          is_right;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                   input logic [DIM_BITS-1:0] lim);
    logic [DIM_BITS-1:0] res;
    if (v == '0) res = DIM_BITS'(1);
    else if (v > lim) res = lim;
    else res = v;
    return res;
  endfunction

  function automatic logic [CHAN_CFG_BITS-1:0] clamp_chan(input logic [CHAN_CFG_BITS-1:0] v);
    logic [CHAN_CFG_BITS-1:0] res;
    if (v == '0) res = CHAN_CFG_BITS'(1);
    else if (v > CHAN_CFG_BITS'(MAX_CHANNELS)) res = CHAN_CFG_BITS'(MAX_CHANNELS);
    else res = v;
    return res;
  endfunction

endpackage

/* rtl/mp2_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
module mp2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/max_pool_2x2_with_argmax_unit.sv */
// Top level: streaming 2x2 stride-2 max pooling with argmax over a line buffer RAM.
//
// Takes one sample per clock with no bubbles as long as the result side keeps up.
// A result goes through the compare/write stage: the accept cycle issues the line
// buffer read, the compare/write stage compares against the upper-row pair best and
// writes or emits, and the output register holds the item. The line buffer (one entry
// per column pair) is written when an upper-row pair completes and read on the
// matching lower-row pair; a write by the item just ahead is forwarded. No clearing
// pass is needed after reset. The user must write frame size and channel count only
// while idle (not enforced); a write to a mapped register restarts the raster.
module max_pool_2x2_with_argmax_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [mp2_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mp2_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mp2_pkg::SAMPLE_BITS-1:0] out_max_value,
  output logic [mp2_pkg::INDEX_BITS-1:0]         out_source_index,
  output logic                                   out_last_of_frame
);
  import mp2_pkg::*;

  // effective (clamped) configuration
  logic [DIM_BITS-1:0]      width_r, height_r;
  logic [CHAN_CFG_BITS-1:0] chans_r;

  // raster position
  logic [COL_BITS-1:0]      col_r;
  logic [ROW_BITS-1:0]      row_r;
  logic [CHAN_BITS-1:0]     chan_r;
  logic [INDEX_BITS-1:0]    idx_r;
  logic signed [SAMPLE_BITS-1:0] pair_r;

  // compare/write stage
  logic                          b_valid_r;
  logic signed [SAMPLE_BITS-1:0] b_value_r;
  logic                          b_right_r;
  logic [SLOT_BITS-1:0]          b_slot_r;
  logic                          b_write_r;
  logic                          b_lower_r;
  logic                          b_xodd_r;
  logic [INDEX_BITS-1:0]         b_idx_r;
  logic                          b_last_r;
  logic                          b_fwd_hit_r;
  slot_t                         b_fwd_data_r;

  // output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic [INDEX_BITS-1:0]         out_idx_r;
  logic                          out_last_r;

  logic acc, b_fire, out_free;
  logic col_last, row_last, chan_last, pair_load, upper_row;
  logic signed [SAMPLE_BITS-1:0] pv;
  logic pr;
  logic [SLOT_BITS-1:0] slot;
  logic fwd_hit;
  slot_t ram_wdata, ram_rdata, up_ent;
  logic take_up;
  logic signed [SAMPLE_BITS-1:0] res_v;
  logic res_r;
  logic [INDEX_BITS-1:0] res_idx;
  logic ram_we, ram_re;

  assign out_free = !out_valid_r || !out_stall;
  assign b_fire   = b_valid_r && (b_write_r || out_free);
  assign in_stall = b_valid_r && !b_fire;
  assign acc      = in_valid && !in_stall;

  assign col_last  = ({1'b0, col_r} + DIM_BITS'(1)) == width_r;
  assign row_last  = ({1'b0, row_r} + DIM_BITS'(1)) == height_r;
  assign chan_last = (CHAN_CFG_BITS'(chan_r) + CHAN_CFG_BITS'(1)) == chans_r;
  assign pair_load = !col_r[0] && !col_last;
  assign upper_row = !row_r[0] && !row_last;
  assign slot      = col_r[COL_BITS-1:1];

  // pair compare, ties to the left sample
  always_comb begin
    if (col_r[0]) begin
      if (pair_r >= in_sample) begin
        pv = pair_r;
        pr = 1'b0;
      end else begin
        pv = in_sample;
        pr = 1'b1;
      end
    end else begin
      pv = in_sample;
      pr = 1'b0;
    end
  end

  assign ram_we          = b_fire && b_write_r;
  assign ram_re          = acc && !pair_load && !upper_row;
  assign ram_wdata.value = b_value_r;
  assign ram_wdata.is_right = b_right_r;
  assign fwd_hit         = ram_we && (b_slot_r == slot);

  mp2_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(HALF_SLOTS)
  ) u_line_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(b_slot_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  // merge with the upper row, ties to the upper row
  always_comb begin
    up_ent  = b_fwd_hit_r ? b_fwd_data_r : ram_rdata;
    take_up = b_lower_r && (up_ent.value >= b_value_r);
    res_v   = take_up ? up_ent.value : b_value_r;
    res_r   = take_up ? up_ent.is_right : b_right_r;
    // current index minus column and row offsets of the winner
    res_idx = b_idx_r - INDEX_BITS'(b_xodd_r && !res_r)
              - (take_up ? INDEX_BITS'(width_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_BITS'(MAX_WIDTH);
      height_r <= DIM_BITS'(HEIGHT_LIMIT);
      chans_r  <= CHAN_CFG_BITS'(1);
      col_r    <= '0;
      row_r    <= '0;
      chan_r   <= '0;
      idx_r    <= '0;
      pair_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          width_r <= clamp_dim(cfg_data, DIM_BITS'(MAX_WIDTH));
        end
        CFG_HEIGHT: begin
          height_r <= clamp_dim(cfg_data, DIM_BITS'(HEIGHT_LIMIT));
        end
        CFG_CHANNELS: begin
          chans_r <= clamp_chan(cfg_data[CHAN_CFG_BITS-1:0]);
        end
        default: begin
        end
      endcase
      if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT || cfg_index == CFG_CHANNELS) begin
        col_r  <= '0;
        row_r  <= '0;
        chan_r <= '0;
        idx_r  <= '0;
        pair_r <= '0;
      end
    end else if (acc) begin
      if (pair_load) begin
        pair_r <= in_sample;
      end
      if (col_last) begin
        col_r <= '0;
        if (row_last) begin
          row_r <= '0;
          chan_r <= chan_last ? '0 : chan_r + CHAN_BITS'(1);
        end else begin
          row_r <= row_r + ROW_BITS'(1);
        end
      end else begin
        col_r <= col_r + COL_BITS'(1);
      end
      idx_r <= (col_last && row_last && chan_last) ? '0 : idx_r + INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (acc && !pair_load) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !pair_load) begin
      b_value_r    <= pv;
      b_right_r    <= pr;
      b_slot_r     <= slot;
      b_write_r    <= upper_row;
      b_lower_r    <= row_r[0];
      b_xodd_r     <= col_r[0];
      b_idx_r      <= idx_r;
      b_last_r     <= col_last && row_last && chan_last;
      b_fwd_hit_r  <= fwd_hit;
      b_fwd_data_r <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire && !b_write_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && !b_write_r) begin
      out_value_r <= res_v;
      out_idx_r   <= res_idx;
      out_last_r  <= b_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_max_value     = out_value_r;
  assign out_source_index  = out_idx_r;
  assign out_last_of_frame = out_last_r;

  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> b_valid_r && !b_write_r && out_valid_r)
    else $error("input stalled without a blocked result");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && !b_write_r |=> out_valid_r)
    else $error("emitted result did not reach output register");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < width_r) && ({1'b0, row_r} < height_r))
    else $error("raster position outside frame");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == CFG_WIDTH |=> col_r == '0 && row_r == '0 && idx_r == '0)
    else $error("config write did not restart raster");

endmodule

/* tb/sv/max_pool_2x2_with_argmax_unit_tb.sv */
// Self-checking testbench for the streaming 2x2 max pooling unit with argmax.
module max_pool_2x2_with_argmax_unit_tb;
  import mp2_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 300;
  localparam int RESET_ITEMS = 32;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [INDEX_BITS-1:0]         source_index;
    logic                          last_of_frame;
  } pooled_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [1:0]                    cfg_index = CFG_WIDTH;
  logic [CFG_BITS-1:0]           cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_max_value;
  logic [INDEX_BITS-1:0]         out_source_index;
  logic                          out_last_of_frame;

  max_pool_2x2_with_argmax_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_max_value     (out_max_value),
    .out_source_index  (out_source_index),
    .out_last_of_frame (out_last_of_frame)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: raw registers and raster position
  logic [DIM_BITS-1:0]           width_reg = DIM_BITS'(1024);
  logic [DIM_BITS-1:0]           height_reg = DIM_BITS'(1024);
  logic [CHAN_CFG_BITS-1:0]      chan_reg = CHAN_CFG_BITS'(1);
  int                            col_pos = 0;
  int                            row_pos = 0;
  int                            chan_pos = 0;
  logic signed [SAMPLE_BITS-1:0] pair_val = '0;
  logic signed [SAMPLE_BITS-1:0] upper_val [HALF_SLOTS];
  logic                          upper_right [HALF_SLOTS];

  pooled_t pooled_due[$];
  int      mismatch_count = 0;
  int      stall_left = 0;
  int      quiet_cycles = 0;
  bit      no_idle = 1'b0;

  function automatic int limit_reg(input int v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // window max with ties to the left sample, then to the upper row
  function automatic void pool_predict(input logic signed [SAMPLE_BITS-1:0] s);
    int                            w, h, nch, p, r, row;
    logic signed [SAMPLE_BITS-1:0] v;
    longint                        idx;
    pooled_t                       res;
    w = limit_reg(int'(width_reg), MAX_WIDTH);
    h = limit_reg(int'(height_reg), HEIGHT_LIMIT);
    nch = limit_reg(int'(chan_reg), MAX_CHANNELS);
    if (col_pos % 2 == 0 && col_pos + 1 < w) begin
      pair_val = s;
    end else begin
      p = col_pos / 2;
      if (col_pos % 2 == 1 && pair_val < s) begin
        v = s;
        r = 1;
      end else if (col_pos % 2 == 1) begin
        v = pair_val;
        r = 0;
      end else begin
        v = s;
        r = 0;
      end
      if (row_pos % 2 == 0 && row_pos + 1 < h) begin
        upper_val[p] = v;
        upper_right[p] = r[0];
      end else begin
        row = row_pos;
        if (row_pos % 2 == 1 && upper_val[p] >= v) begin
          v = upper_val[p];
          r = int'(upper_right[p]);
          row = row_pos - 1;
        end
        idx = longint'(chan_pos) * h * w + longint'(row) * w + 2 * p + r;
        res.max_value = v;
        res.source_index = idx[INDEX_BITS-1:0];
        res.last_of_frame = (col_pos == w - 1) && (row_pos == h - 1) && (chan_pos == nch - 1);
        pooled_due.push_back(res);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        chan_pos++;
        if (chan_pos >= nch) chan_pos = 0;
      end
    end
  endfunction

  // biased toward extremes and small values so ties come up often
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 7))
      0: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2, 3: s = SAMPLE_BITS'($urandom_range(0, 3)) - SAMPLE_BITS'(1);
      default: s = SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  // in_valid is only lowered after a gap is drawn, so it never toggles within one step
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool_predict(s);
  endtask

  task automatic send_random(input int n);
    repeat (n) push_sample(pick_sample());
  endtask

  // drain all expected results, then let trailing items clear the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (pooled_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_WIDTH) width_reg = val;
    else if (idx == CFG_HEIGHT) height_reg = val;
    else if (idx == CFG_CHANNELS) chan_reg = val[CHAN_CFG_BITS-1:0];
    if (idx != CFG_SPARE) begin
      col_pos = 0;
      row_pos = 0;
      chan_pos = 0;
      pair_val = '0;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h, input int nch);
    settle();
    write_reg(CFG_WIDTH, CFG_BITS'(w));
    write_reg(CFG_HEIGHT, CFG_BITS'(h));
    write_reg(CFG_CHANNELS, CFG_BITS'(nch));
  endtask

  // reset geometry is 1024 x 1024 x 1: the first row only fills the line buffer
  task automatic test_reset_geometry();
    send_random(RESET_ITEMS);
  endtask

  // odd 3x3 frame, two channels: full ties, extremes, partial windows, last flag
  task automatic test_directed_windows();
    logic signed [SAMPLE_BITS-1:0] pattern [18];
    pattern = '{16'sd5, 16'sd5, 16'sh8000,
                16'sd5, 16'sd5, 16'sd32767,
                16'sd32767, 16'sh8000, 16'sd7,
                -16'sd1, 16'sd3, 16'sd100,
                16'sd3, 16'sd3, 16'sd100,
                16'sh8000, 16'sh8000, 16'sh8000};
    set_frame(3, 3, 2);
    foreach (pattern[k]) push_sample(pattern[k]);
  endtask

  task automatic test_register_limits();
    // width clamps to the maximum; the first lower-row pair reads the line buffer
    set_frame(2047, 2, 1);
    send_random(MAX_WIDTH + 2);
    set_frame(1, 2047, 1);                   // height clamps to the maximum
    send_random(HEIGHT_LIMIT);
    set_frame(1, 1, 511);                    // channels clamp, run past the wrap
    send_random(MAX_CHANNELS + 2);
    set_frame(0, 0, 256);                    // zero counts as one
    send_random(16);
    set_frame(2, 2, 11'h600);                // upper bits of channel write are dropped
    send_random(8);
  endtask

  // a write restarts the raster; the unmapped index does not
  task automatic test_restart();
    set_frame(5, 3, 2);
    send_random(7);
    settle();
    write_reg(CFG_SPARE, CFG_BITS'($urandom));
    send_random(8);
    settle();
    write_reg(CFG_CHANNELS, CFG_BITS'(2));
    send_random(30);
  endtask

  task automatic test_random_frames();
    int w, h, nch, frame, n, sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(17, 40);
        h = $urandom_range(0, 1);
        nch = 1;
      end else begin
        w = $urandom_range(1, 16);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        nch = $urandom_range(0, 4);
      end
      set_frame(w, h, nch);
      no_idle = ($urandom_range(0, 3) == 0);
      frame = limit_reg(w, MAX_WIDTH) * limit_reg(h, HEIGHT_LIMIT) * limit_reg(nch, MAX_CHANNELS);
      n = frame * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(0, frame - 1);
      if ($urandom_range(0, 5) == 0) begin
        // spare write in the middle of a frame must not disturb it
        send_random(n / 2);
        settle();
        write_reg(CFG_SPARE, CFG_BITS'($urandom));
        send_random(n - n / 2);
      end else begin
        send_random(n);
      end
      sent += n;
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    pooled_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pooled_due.size() == 0) begin
        $error("unexpected result: max_value %0d source_index %0d", out_max_value,
               out_source_index);
        mismatch_count++;
      end else begin
        want = pooled_due.pop_front();
        if (out_max_value !== want.max_value) begin
          $error("max_value: expected %0d, got %0d", want.max_value, out_max_value);
          mismatch_count++;
        end
        if (out_source_index !== want.source_index) begin
          $error("source_index: expected %0d, got %0d", want.source_index, out_source_index);
          mismatch_count++;
        end
        if (out_last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0b, got %0b", want.last_of_frame, out_last_of_frame);
          mismatch_count++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 10);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("max_pool_2x2_with_argmax_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_geometry();
    test_directed_windows();
    test_register_limits();
    test_restart();
    test_random_frames();
    settle();
    if (mismatch_count == 0) begin
      $display("max_pool_2x2_with_argmax_unit_tb OK");
    end else begin
      $display("max_pool_2x2_with_argmax_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* max_pool_2x2_with_argmax_unit.f */
rtl/mp2_pkg.sv
rtl/mp2_ram.sv
rtl/max_pool_2x2_with_argmax_unit.sv
tb/sv/max_pool_2x2_with_argmax_unit_tb.sv
